/* sv/cse_pkg.sv */
// Package with the types, codes and helper functions of the C string escape decoder.
package cse_pkg;

    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_ESCAPE   = 2'd1,
        ST_BAD_HEX      = 2'd2,
        ST_UNTERMINATED = 2'd3
    } status_t;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] high_nibble;
        status_t    error_status;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{phase: PH_OPEN, high_nibble: 4'd0,
                                           error_status: ST_OK};

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_value(input logic [7:0] b);
        hex_digit_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.value = 4'(b - 8'h61 + 8'd10);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.value = 4'(b - 8'h41 + 8'd10);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* sv/cse_if.sv */
// Stream interfaces for the raw literal bytes and the decoded results.
interface cse_in_if
    import cse_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cse_out_if
    import cse_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/c_string_escape_decoder.sv */
// Top level of the C string escape decoder: input register, decode step, result register.
//
//   Port      Dir    Payload                                         Transaction
//   literal   sink   in_byte[7:0], is_last                           one raw byte
//   decoded   source out_byte[7:0], byte_valid, end_of_string,       zero or one per byte
//                    status[1:0]
//
// One byte per cycle sustained while decoded.ready stays high; a result passes the input and result registers.
// The limit is the single decode step between the input and result registers.
// Reset returns the decoder to awaiting the opening byte and empties both registers.
// While a result waits for decoded.ready, one more byte can still be taken into the
// input register; it is decoded as soon as the result register frees.
module c_string_escape_decoder
    import cse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    cse_in_if.sink           literal,
    cse_out_if.source        decoded
);

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    logic       step_emit;
    out_item_t  step_result;
    logic       slot_free;
    logic       step_fire;

    assign slot_free     = !out_valid_reg || decoded.ready;
    assign step_fire     = in_valid_reg && slot_free;
    assign literal.ready = !in_valid_reg || slot_free;

    assign decoded.valid   = out_valid_reg;
    assign decoded.payload = out_item_reg;

    cse_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (literal.valid && literal.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step_fire)
            begin
                out_valid_reg <= step_emit;
                state_reg     <= state_next;
            end
            else if (decoded.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (literal.valid && literal.ready)
        begin
            in_item_reg <= literal.payload;
        end
        if (step_fire && step_emit)
        begin
            out_item_reg <= step_result;
        end
    end

    // The closing byte always returns the decoder to its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && in_item_reg.is_last |=> state_reg == STATE_RESET)
        else $error("decoder state not cleared after closing byte");

    // Once an error is kept, no escape stays open.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error_status != ST_OK |-> state_reg.phase == PH_BODY)
        else $error("escape phase open while an error is kept");

    // A nonzero status appears only on the end-of-string result, which carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.status != ST_OK || out_item_reg.end_of_string)
        |-> out_item_reg.end_of_string && !out_item_reg.byte_valid
            && out_item_reg.out_byte == 8'd0)
        else $error("malformed end-of-string result");

    // Every result is either a decoded byte or the end marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.byte_valid != out_item_reg.end_of_string)
        else $error("result is neither a byte nor an end marker");

endmodule

/* sv/cse_step.sv */
// Combinational decode step: next decoder state and the result for one byte.
module cse_step
    import cse_pkg::*;
(
    input  dec_state_t state,
    input  in_item_t   item,
    output dec_state_t state_next,
    output logic       emit,
    output out_item_t  result
);

    hex_digit_t hex;

    assign hex = hex_value(item.in_byte);

    // Next state.
    always_comb
    begin
        state_next = state;
        if (item.is_last)
        begin
            state_next = STATE_RESET;
        end
        else if (state.phase == PH_OPEN)
        begin
            state_next.phase = PH_BODY;
        end
        else if (state.error_status == ST_OK)
        begin
            unique case (state.phase)
                PH_ESC:
                begin
                    state_next.phase = PH_BODY;
                    unique case (item.in_byte)
                        CH_QUOTE, CH_BACKSLASH, CH_N, CH_T, CH_R: ;
                        CH_X:    state_next.phase = PH_HEX1;
                        default: state_next.error_status = ST_BAD_ESCAPE;
                    endcase
                end
                PH_HEX1:
                begin
                    if (hex.ok)
                    begin
                        state_next.high_nibble = hex.value;
                        state_next.phase       = PH_HEX2;
                    end
                    else
                    begin
                        state_next.error_status = ST_BAD_HEX;
                        state_next.phase        = PH_BODY;
                    end
                end
                PH_HEX2:
                begin
                    state_next.phase = PH_BODY;
                    if (hex.ok)
                    begin
                        state_next.high_nibble = 4'd0;
                    end
                    else
                    begin
                        state_next.error_status = ST_BAD_HEX;
                    end
                end
                default:
                begin
                    // The body phase, and any phase code that is never reached.
                    state_next.phase = (item.in_byte == CH_BACKSLASH) ? PH_ESC : PH_BODY;
                end
            endcase
        end
    end

    // Result.
    always_comb
    begin
        emit   = 1'b0;
        result = '0;
        if (item.is_last)
        begin
            emit                 = 1'b1;
            result.end_of_string = 1'b1;
            if (state.error_status != ST_OK)
            begin
                result.status = state.error_status;
            end
            else if (state.phase == PH_ESC || state.phase == PH_HEX1
                     || state.phase == PH_HEX2)
            begin
                result.status = ST_UNTERMINATED;
            end
        end
        else if (state.phase != PH_OPEN && state.error_status == ST_OK)
        begin
            unique case (state.phase)
                PH_ESC:
                begin
                    emit = 1'b1;
                    unique case (item.in_byte)
                        CH_QUOTE:     result.out_byte = CH_QUOTE;
                        CH_BACKSLASH: result.out_byte = CH_BACKSLASH;
                        CH_N:         result.out_byte = CH_NEWLINE;
                        CH_T:         result.out_byte = CH_TAB;
                        CH_R:         result.out_byte = CH_CR;
                        default:      emit = 1'b0;
                    endcase
                    result.byte_valid = emit;
                end
                PH_HEX1: ;
                PH_HEX2:
                begin
                    emit              = hex.ok;
                    result.byte_valid = hex.ok;
                    result.out_byte   = hex.ok ? {state.high_nibble, hex.value} : 8'd0;
                end
                default:
                begin
                    if (item.in_byte != CH_BACKSLASH)
                    begin
                        emit              = 1'b1;
                        result.byte_valid = 1'b1;
                        result.out_byte   = item.in_byte;
                    end
                end
            endcase
        end
    end

endmodule

/* dv/cse_unescape_checker.sv */
// Checker that predicts the decoded results of the escape decoder and compares them.
module cse_unescape_checker
    import cse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      lit_valid,
    input  logic      lit_ready,
    input  in_item_t  lit_item,
    input  logic      dec_valid,
    input  logic      dec_ready,
    input  out_item_t dec_item,
    output int        mismatches,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t     lit_phase;
    logic [3:0] first_nibble;
    status_t    kept_error;
    out_item_t  expected_decoded[$];

    // Value of a hex digit in the low four bits; bit 4 set means not a hex digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9")
        begin
            return 5'(b - "0");
        end
        if (b >= "a" && b <= "f")
        begin
            return 5'(b - "a" + 8'd10);
        end
        if (b >= "A" && b <= "F")
        begin
            return 5'(b - "A" + 8'd10);
        end
        return 5'h10;
    endfunction

    // Advances the decoder state by one raw byte; returns 1 when it yields a result.
    function automatic bit unescape_step(input in_item_t it, output out_item_t res);
        logic [4:0] nib;
        res = '0;
        if (it.is_last)
        begin
            res.end_of_string = 1'b1;
            res.status        = kept_error;
            if (kept_error == ST_OK &&
                (lit_phase == PH_ESC || lit_phase == PH_HEX1 || lit_phase == PH_HEX2))
            begin
                res.status = ST_UNTERMINATED;
            end
            lit_phase    = PH_OPEN;
            first_nibble = 4'd0;
            kept_error   = ST_OK;
            return 1'b1;
        end
        if (lit_phase == PH_OPEN)
        begin
            lit_phase = PH_BODY;
            return 1'b0;
        end
        // Once an error is kept, the rest of the body is swallowed.
        if (kept_error != ST_OK)
        begin
            return 1'b0;
        end
        case (lit_phase)
            PH_ESC:
            begin
                lit_phase      = PH_BODY;
                res.byte_valid = 1'b1;
                case (it.in_byte)
                    CH_QUOTE:     res.out_byte = CH_QUOTE;
                    CH_BACKSLASH: res.out_byte = CH_BACKSLASH;
                    CH_N:         res.out_byte = CH_NEWLINE;
                    CH_T:         res.out_byte = CH_TAB;
                    CH_R:         res.out_byte = CH_CR;
                    CH_X:
                    begin
                        lit_phase = PH_HEX1;
                        return 1'b0;
                    end
                    default:
                    begin
                        kept_error = ST_BAD_ESCAPE;
                        return 1'b0;
                    end
                endcase
                return 1'b1;
            end
            PH_HEX1:
            begin
                nib = nibble_of(it.in_byte);
                if (nib[4])
                begin
                    kept_error = ST_BAD_HEX;
                    lit_phase  = PH_BODY;
                    return 1'b0;
                end
                first_nibble = nib[3:0];
                lit_phase    = PH_HEX2;
                return 1'b0;
            end
            PH_HEX2:
            begin
                nib       = nibble_of(it.in_byte);
                lit_phase = PH_BODY;
                if (nib[4])
                begin
                    kept_error = ST_BAD_HEX;
                    return 1'b0;
                end
                res.out_byte   = {first_nibble, nib[3:0]};
                res.byte_valid = 1'b1;
                first_nibble   = 4'd0;
                return 1'b1;
            end
            default:
            begin
                lit_phase = PH_BODY;
                if (it.in_byte == CH_BACKSLASH)
                begin
                    lit_phase = PH_ESC;
                    return 1'b0;
                end
                res.out_byte   = it.in_byte;
                res.byte_valid = 1'b1;
                return 1'b1;
            end
        endcase
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t fresh;
        if (!rst_n)
        begin
            lit_phase    = PH_OPEN;
            first_nibble = 4'd0;
            kept_error   = ST_OK;
            expected_decoded.delete();
        end
        else
        begin
            // A result never leaves in the cycle its byte is taken, so compare first.
            if (dec_valid && dec_ready)
            begin
                if (expected_decoded.size() == 0)
                begin
                    $error("unexpected result transaction: out_byte %0h status %0d",
                           dec_item.out_byte, dec_item.status);
                    mismatches++;
                end
                else
                begin
                    want = expected_decoded.pop_front();
                    if (dec_item.out_byte !== want.out_byte)
                    begin
                        $error("out_byte expected %0h actual %0h",
                               want.out_byte, dec_item.out_byte);
                        mismatches++;
                    end
                    if (dec_item.byte_valid !== want.byte_valid)
                    begin
                        $error("byte_valid expected %0b actual %0b",
                               want.byte_valid, dec_item.byte_valid);
                        mismatches++;
                    end
                    if (dec_item.end_of_string !== want.end_of_string)
                    begin
                        $error("end_of_string expected %0b actual %0b",
                               want.end_of_string, dec_item.end_of_string);
                        mismatches++;
                    end
                    if (dec_item.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d",
                               want.status, dec_item.status);
                        mismatches++;
                    end
                end
            end
            if (lit_valid && lit_ready)
            begin
                if (unescape_step(lit_item, fresh))
                begin
                    expected_decoded.push_back(fresh);
                end
            end
        end
        outstanding = expected_decoded.size();
    end

endmodule

/* dv/testbench.sv */
// Top of the escape decoder testbench: clock, reset, literal stimulus and verdict.
module testbench;
    import cse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_ITEMS = 1280;
    localparam int CYCLE_LIMIT  = 500000;

    logic       clk;
    logic       rst_n;
    int         mismatches;
    int         outstanding;
    int         items_sent;
    int         cycles;
    bit         calm;
    int         calm_left;
    int         stall_left;
    logic [7:0] lit_body[$];

    cse_in_if  literal_if();
    cse_out_if decoded_if();

    c_string_escape_decoder dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .literal (literal_if),
        .decoded (decoded_if)
    );

    cse_unescape_checker unescape_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .lit_valid   (literal_if.valid),
        .lit_ready   (literal_if.ready),
        .lit_item    (literal_if.payload),
        .dec_valid   (decoded_if.valid),
        .dec_ready   (decoded_if.ready),
        .dec_item    (decoded_if.payload),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none at all during calm stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Result-side back-pressure, with calm stretches switched on now and then.
    always @(negedge clk)
    begin
        int r;
        if (calm_left == 0)
        begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(50, 300);
        end
        else
        begin
            calm_left--;
        end
        if (!rst_n)
        begin
            decoded_if.ready <= 1'b0;
        end
        else if (calm)
        begin
            decoded_if.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            decoded_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                decoded_if.ready <= 1'b1;
            end
            else
            begin
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                decoded_if.ready <= 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            literal_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        literal_if.valid   <= 1'b1;
        literal_if.payload <= '{in_byte: b, is_last: last};
        do
            @(posedge clk);
        while (!literal_if.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_literal(input logic [7:0] open_b, input logic [7:0] close_b);
        send_byte(open_b, 1'b0);
        foreach (lit_body[i])
        begin
            send_byte(lit_body[i], 1'b0);
        end
        send_byte(close_b, 1'b1);
        lit_body.delete();
    endtask

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return 8'("0" + v);
        end
        return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h00, 8'h2F));
            1:       return 8'($urandom_range(8'h3A, 8'h40));
            2:       return 8'($urandom_range(8'h47, 8'h60));
            default: return 8'($urandom_range(8'h67, 8'hFF));
        endcase
    endfunction

    function automatic logic [7:0] bad_letter();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b inside {CH_QUOTE, CH_BACKSLASH, CH_N, CH_T, CH_R, CH_X});
        return b;
    endfunction

    task automatic add_good_piece();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            // A random backslash is doubled so the piece stays well formed.
            b = 8'($urandom_range(0, 255));
            lit_body.push_back(b);
            if (b == CH_BACKSLASH)
            begin
                lit_body.push_back(CH_BACKSLASH);
            end
        end
        else if (r < 80)
        begin
            lit_body.push_back(CH_BACKSLASH);
            case ($urandom_range(0, 4))
                0:       lit_body.push_back(CH_QUOTE);
                1:       lit_body.push_back(CH_BACKSLASH);
                2:       lit_body.push_back(CH_N);
                3:       lit_body.push_back(CH_T);
                default: lit_body.push_back(CH_R);
            endcase
        end
        else
        begin
            lit_body.push_back(CH_BACKSLASH);
            lit_body.push_back(CH_X);
            lit_body.push_back(hex_char());
            lit_body.push_back(hex_char());
        end
    endtask

    task automatic add_bad_piece();
        lit_body.push_back(CH_BACKSLASH);
        case ($urandom_range(0, 2))
            0:
            begin
                lit_body.push_back(bad_letter());
            end
            1:
            begin
                lit_body.push_back(CH_X);
                lit_body.push_back(non_hex_char());
            end
            default:
            begin
                lit_body.push_back(CH_X);
                lit_body.push_back(hex_char());
                lit_body.push_back(non_hex_char());
            end
        endcase
    endtask

    task automatic send_random_literal();
        int         n;
        int         kind;
        logic [7:0] open_b;
        logic [7:0] close_b;
        open_b  = ($urandom_range(0, 99) < 85) ? CH_QUOTE : 8'($urandom_range(0, 255));
        close_b = ($urandom_range(0, 99) < 85) ? CH_QUOTE : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 3)
        begin
            send_byte(close_b, 1'b1);
            return;
        end
        n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 10) : $urandom_range(11, 40);
        repeat (n) add_good_piece();
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            add_bad_piece();
            repeat ($urandom_range(0, 3)) add_good_piece();
        end
        else if (kind < 18)
        begin
            // Leave an escape open at the closing byte.
            lit_body.push_back(CH_BACKSLASH);
            case ($urandom_range(0, 2))
                0:       ;
                1:       lit_body.push_back(CH_X);
                default:
                begin
                    lit_body.push_back(CH_X);
                    lit_body.push_back(hex_char());
                end
            endcase
        end
        send_literal(open_b, close_b);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        literal_if.valid   = 1'b0;
        literal_if.payload = '0;
        decoded_if.ready   = 1'b0;
        items_sent         = 0;
        cycles             = 0;
        calm               = 1'b0;
        calm_left          = 0;
        stall_left         = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty literal given as a single closing byte.
        send_byte(CH_QUOTE, 1'b1);
        // Byte extremes, a hex escape in both cases and a newline escape.
        lit_body = {8'h00, 8'hFF, CH_BACKSLASH, CH_X, "F", "a", CH_BACKSLASH, CH_N};
        send_literal(CH_QUOTE, CH_QUOTE);
        // Bad escape letter; the valid escape after it must be ignored.
        lit_body = {CH_BACKSLASH, "q", CH_BACKSLASH, CH_QUOTE};
        send_literal(CH_QUOTE, CH_QUOTE);
        // Bad second hex digit.
        lit_body = {CH_BACKSLASH, CH_X, "7", "g"};
        send_literal(CH_QUOTE, CH_QUOTE);
        // Escape still waiting for its first hex digit at the closing byte.
        lit_body = {CH_BACKSLASH, CH_X};
        send_literal(CH_QUOTE, CH_QUOTE);

        while (items_sent < TARGET_ITEMS)
        begin
            send_random_literal();
        end
        literal_if.valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
sv/cse_pkg.sv
sv/cse_if.sv
sv/cse_step.sv
sv/c_string_escape_decoder.sv
dv/cse_unescape_checker.sv
dv/testbench.sv
